FILE: rtl/core/cpu8_pkg.sv
// Package with shared constants and types for the 8-bit load/ALU execute unit.
package cpu8_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    localparam logic [7:0] HIGH_PAGE = 8'hFF;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBC = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CP  = 3'd7
    } alu_op_t;

    // Register file indexes; code 6 means (HL), code 7 means A.
    localparam logic [2:0] REG_B  = 3'd0;
    localparam logic [2:0] REG_C  = 3'd1;
    localparam logic [2:0] REG_D  = 3'd2;
    localparam logic [2:0] REG_E  = 3'd3;
    localparam logic [2:0] REG_H  = 3'd4;
    localparam logic [2:0] REG_L  = 3'd5;
    localparam logic [2:0] REG_HL = 3'd6;
    localparam logic [2:0] REG_A  = 3'd7;

    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_HALT    = 8'h76;
    localparam logic [7:0] OP_LD_BC_A = 8'h02;
    localparam logic [7:0] OP_LD_DE_A = 8'h12;
    localparam logic [7:0] OP_LD_HLI_A = 8'h22;
    localparam logic [7:0] OP_LD_HLD_A = 8'h32;
    localparam logic [7:0] OP_LD_A_BC = 8'h0A;
    localparam logic [7:0] OP_LD_A_DE = 8'h1A;
    localparam logic [7:0] OP_LD_A_HLI = 8'h2A;
    localparam logic [7:0] OP_LD_A_HLD = 8'h3A;
    localparam logic [7:0] OP_LDH_A8_A = 8'hE0;
    localparam logic [7:0] OP_LDH_A_A8 = 8'hF0;
    localparam logic [7:0] OP_LD_C_A  = 8'hE2;
    localparam logic [7:0] OP_LD_A_C  = 8'hF2;
    localparam logic [7:0] OP_LD_A16_A = 8'hEA;
    localparam logic [7:0] OP_LD_A_A16 = 8'hFA;

    // Result of decoding one instruction.
    typedef struct packed {
        logic        unimpl;
        logic        mem_rd;     // operand or A comes from memory
        logic        mem_wr;     // a byte is stored
        logic        is_alu;
        alu_op_t     alu_op;
        logic        dst_en;     // register destination written
        logic [2:0]  dst;        // register code (not 6 when dst_en is set)
        logic        src_imm;    // value is imm_first
        logic [2:0]  src;        // register code for source value
        logic        hl_inc;
        logic        hl_dec;
        logic [15:0] addr;
        logic [1:0]  len;
    } dec_t;

endpackage

FILE: rtl/core/cpu8_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cpu8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/cpu8_load_alu_execute_unit.sv
// Top level of the 8-bit load/ALU execute unit.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+--------------------------------------
//  in      | input     | in_valid/in_ready | opcode, imm_first, imm_second
//  out     | output    | out_valid/out_ready | next_pc, acc_value, flag_bits,
//          |           |                  | pair_bc/de/hl, mem_written,
//          |           |                  | write_addr, write_data, unimplemented
//
// An instruction word is decoded in the cycle it is accepted and the data memory
// read is issued then; when it retires, the registered read data is used, the
// registers, flags and PC are updated, any store is written and the result word
// is loaded into the output register. The execute stage holds one instruction, and
// a new word is accepted in the same cycle the previous one retires, so with no
// stalls the block takes one word per cycle: registers retiring in that cycle are
// forwarded to decode, and a store to the entry being read is forwarded to the read.
// The output register lets a new word be accepted while a result waits.
// Reset clears the registers, flags, PC and all valid bits; memory is not cleared.
module cpu8_load_alu_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  opcode,
    input  logic [7:0]  imm_first,
    input  logic [7:0]  imm_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] next_pc,
    output logic [7:0]  acc_value,
    output logic [3:0]  flag_bits,
    output logic [15:0] pair_bc,
    output logic [15:0] pair_de,
    output logic [15:0] pair_hl,
    output logic        mem_written,
    output logic [15:0] write_addr,
    output logic [7:0]  write_data,
    output logic        unimplemented
);
    import cpu8_pkg::*;

    // Architectural state.
    logic [7:0]  gpr_reg [8];
    logic [7:0]  gpr_next [8];
    logic [3:0]  flag_reg, flag_next;
    logic [15:0] pc_reg, pc_next;

    // Execute stage.
    logic        ex_valid_reg;
    dec_t        ex_dec_reg;
    logic [7:0]  ex_imm_reg;

    // Output register.
    logic        out_valid_reg;

    logic        in_fire, out_fire, ex_fire;
    dec_t        dec;
    logic [7:0]  mem_rd_data;
    logic [15:0] hl_now;

    // The execute stage may retire when the output register is free or draining.
    assign ex_fire  = ex_valid_reg && (!out_valid_reg || out_ready);
    // Only one instruction in flight, so decode never sees stale registers.
    assign in_ready = !ex_valid_reg || ex_fire;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;

    // Registers seen by decode: when the previous instruction retires in this
    // same cycle, its results are forwarded.
    logic [7:0] cur [8];
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cur[i] = ex_fire ? gpr_next[i] : gpr_reg[i];
        end
    end
    assign hl_now = {cur[REG_H], cur[REG_L]};

    // Decode.
    always_comb
    begin
        dec = '0;
        dec.alu_op = ALU_ADD;
        dec.len = 2'd1;
        dec.src = opcode[2:0];
        dec.dst = opcode[5:3];
        dec.addr = hl_now;
        if (opcode == OP_NOP)
        begin
        end
        else if (opcode[7:6] == 2'b01 && opcode != OP_HALT)
        begin
            dec.mem_rd = (opcode[2:0] == REG_HL);
            dec.mem_wr = (opcode[5:3] == REG_HL);
            dec.dst_en = !dec.mem_wr;
        end
        else if (opcode[7:6] == 2'b00 && opcode[2:0] == 3'd6)
        begin
            dec.len = 2'd2;
            dec.src_imm = 1'b1;
            dec.mem_wr = (opcode[5:3] == REG_HL);
            dec.dst_en = !dec.mem_wr;
        end
        else if (opcode[7:6] == 2'b10)
        begin
            dec.is_alu = 1'b1;
            dec.alu_op = alu_op_t'(opcode[5:3]);
            dec.mem_rd = (opcode[2:0] == REG_HL);
        end
        else
        begin
            dec.src = REG_A;
            dec.dst = REG_A;
            unique case (opcode)
                OP_LD_BC_A:  begin dec.mem_wr = 1'b1; dec.addr = {cur[REG_B], cur[REG_C]}; end
                OP_LD_DE_A:  begin dec.mem_wr = 1'b1; dec.addr = {cur[REG_D], cur[REG_E]}; end
                OP_LD_HLI_A: begin dec.mem_wr = 1'b1; dec.hl_inc = 1'b1; end
                OP_LD_HLD_A: begin dec.mem_wr = 1'b1; dec.hl_dec = 1'b1; end
                OP_LD_A_BC:
                begin
                    dec.mem_rd = 1'b1; dec.dst_en = 1'b1;
                    dec.addr = {cur[REG_B], cur[REG_C]};
                end
                OP_LD_A_DE:
                begin
                    dec.mem_rd = 1'b1; dec.dst_en = 1'b1;
                    dec.addr = {cur[REG_D], cur[REG_E]};
                end
                OP_LD_A_HLI: begin dec.mem_rd = 1'b1; dec.dst_en = 1'b1; dec.hl_inc = 1'b1; end
                OP_LD_A_HLD: begin dec.mem_rd = 1'b1; dec.dst_en = 1'b1; dec.hl_dec = 1'b1; end
                OP_LDH_A8_A:
                begin
                    dec.mem_wr = 1'b1; dec.len = 2'd2; dec.addr = {HIGH_PAGE, imm_first};
                end
                OP_LDH_A_A8:
                begin
                    dec.mem_rd = 1'b1; dec.dst_en = 1'b1; dec.len = 2'd2;
                    dec.addr = {HIGH_PAGE, imm_first};
                end
                OP_LD_C_A:   begin dec.mem_wr = 1'b1; dec.addr = {HIGH_PAGE, cur[REG_C]}; end
                OP_LD_A_C:
                begin
                    dec.mem_rd = 1'b1; dec.dst_en = 1'b1; dec.addr = {HIGH_PAGE, cur[REG_C]};
                end
                OP_LD_A16_A:
                begin
                    dec.mem_wr = 1'b1; dec.len = 2'd3; dec.addr = {imm_second, imm_first};
                end
                OP_LD_A_A16:
                begin
                    dec.mem_rd = 1'b1; dec.dst_en = 1'b1; dec.len = 2'd3;
                    dec.addr = {imm_second, imm_first};
                end
                default:     dec.unimpl = 1'b1;
            endcase
        end
        // Addresses are kept to the memory size.
        dec.addr = {{(16 - ADDR_BITS){1'b0}}, dec.addr[ADDR_BITS-1:0]};
    end

    // Data memory: read issued at accept, store written at retire.
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [7:0]           store_data;

    cpu8_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (store_data),
        .rd_en   (in_fire && dec.mem_rd),
        .rd_addr (dec.addr[ADDR_BITS-1:0]),
        .rd_data (mem_rd_data)
    );

    // A read whose entry is stored in the same cycle gets the stored byte.
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;
    logic [7:0] mem_value;
    assign mem_value = fwd_reg ? fwd_data_reg : mem_rd_data;

    // Execute.
    logic [7:0] src_val, alu_res;
    logic [3:0] alu_flags;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic       cin;
    logic [15:0] hl_ex;

    assign hl_ex = {gpr_reg[REG_H], gpr_reg[REG_L]};

    always_comb
    begin
        if (ex_dec_reg.src_imm)
        begin
            src_val = ex_imm_reg;
        end
        else if (ex_dec_reg.mem_rd)
        begin
            src_val = mem_value;
        end
        else
        begin
            src_val = gpr_reg[ex_dec_reg.src];
        end
    end

    always_comb
    begin
        cin = 1'b0;
        sum9 = '0;
        sum5 = '0;
        alu_res = '0;
        alu_flags = '0;
        case (ex_dec_reg.alu_op)
            ALU_ADD, ALU_ADC:
            begin
                cin = (ex_dec_reg.alu_op == ALU_ADC) && flag_reg[0];
                sum9 = {1'b0, gpr_reg[REG_A]} + {1'b0, src_val} + {8'd0, cin};
                sum5 = {1'b0, gpr_reg[REG_A][3:0]} + {1'b0, src_val[3:0]} + {4'd0, cin};
                alu_res = sum9[7:0];
                alu_flags = {1'b0, 1'b0, sum5[4], sum9[8]};
            end
            ALU_SUB, ALU_SBC, ALU_CP:
            begin
                cin = (ex_dec_reg.alu_op == ALU_SBC) && flag_reg[0];
                sum9 = {1'b0, gpr_reg[REG_A]} - {1'b0, src_val} - {8'd0, cin};
                sum5 = {1'b0, gpr_reg[REG_A][3:0]} - {1'b0, src_val[3:0]} - {4'd0, cin};
                alu_res = sum9[7:0];
                alu_flags = {1'b0, 1'b1, sum5[4], sum9[8]};
            end
            ALU_AND:
            begin
                alu_res = gpr_reg[REG_A] & src_val;
                alu_flags = 4'b0010;
            end
            ALU_XOR: alu_res = gpr_reg[REG_A] ^ src_val;
            default: alu_res = gpr_reg[REG_A] | src_val;
        endcase
        alu_flags[3] = (alu_res == 8'd0);
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            gpr_next[i] = gpr_reg[i];
        end
        flag_next = flag_reg;
        pc_next = pc_reg + {14'd0, ex_dec_reg.len};
        if (ex_dec_reg.is_alu)
        begin
            flag_next = alu_flags;
            if (ex_dec_reg.alu_op != ALU_CP)
            begin
                gpr_next[REG_A] = alu_res;
            end
        end
        else if (ex_dec_reg.dst_en)
        begin
            gpr_next[ex_dec_reg.dst] = src_val;
        end
        if (ex_dec_reg.hl_inc)
        begin
            {gpr_next[REG_H], gpr_next[REG_L]} = hl_ex + 16'd1;
        end
        else if (ex_dec_reg.hl_dec)
        begin
            {gpr_next[REG_H], gpr_next[REG_L]} = hl_ex - 16'd1;
        end
        gpr_next[REG_HL] = 8'd0;
    end

    assign store_data = src_val;
    assign ram_we     = ex_fire && ex_dec_reg.mem_wr;
    assign ram_waddr  = ex_dec_reg.addr[ADDR_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                gpr_reg[i] <= '0;
            end
            flag_reg      <= '0;
            pc_reg        <= '0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (ex_fire)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    gpr_reg[i] <= gpr_next[i];
                end
                flag_reg <= flag_next;
                pc_reg   <= pc_next;
            end
            if (in_fire)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            // The forwarded byte stays with its instruction while it waits to retire.
            if (in_fire)
            begin
                fwd_reg <= dec.mem_rd && ram_we && (ram_waddr == dec.addr[ADDR_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ex_dec_reg   <= dec;
            ex_imm_reg   <= imm_first;
            fwd_data_reg <= store_data;
        end
        if (ex_fire)
        begin
            next_pc       <= pc_next;
            acc_value     <= gpr_next[REG_A];
            flag_bits     <= flag_next;
            pair_bc       <= {gpr_next[REG_B], gpr_next[REG_C]};
            pair_de       <= {gpr_next[REG_D], gpr_next[REG_E]};
            pair_hl       <= {gpr_next[REG_H], gpr_next[REG_L]};
            mem_written   <= ex_dec_reg.mem_wr;
            write_addr    <= ex_dec_reg.mem_wr ? ex_dec_reg.addr : 16'd0;
            write_data    <= ex_dec_reg.mem_wr ? store_data : 8'd0;
            unimplemented <= ex_dec_reg.unimpl;
        end
    end

    // The execute stage never retires into a full, stalled output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire |-> (!out_valid_reg || out_ready))
        else $error("execute retired into a stalled output register");

    // A new word is never taken while the execute stage holds one that cannot leave.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ex_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while execute stage blocked");

    // Every retire leaves a valid result the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire |=> out_valid_reg)
        else $error("retired instruction produced no result");

    // An unimplemented opcode never stores.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ex_valid_reg && ex_dec_reg.unimpl) |-> !ex_dec_reg.mem_wr)
        else $error("unimplemented opcode marked as store");

endmodule

FILE: sim/tb_top.sv
// Testbench for the 8-bit load/ALU execute unit: a directed table, then random words.
module tb_top;
    import cpu8_pkg::*;

    // One result word as the block reports it after an instruction.
    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a;
        logic [3:0]  f;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic        w;
        logic [15:0] wa;
        logic [7:0]  wd;
        logic        u;
    } state_word_t;

    // One row of the directed table. When typed is set, the expected word is the
    // one written in the row; otherwise it comes from the instruction predictor.
    typedef struct packed {
        logic [7:0]  op;
        logic [7:0]  i1;
        logic [7:0]  i2;
        logic        typed;
        state_word_t r;
    } dir_row_t;

    localparam int NUM_DIR = 33;
    localparam int NUM_RAND = 1300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [15:0] ADDR_MASK = 16'(MEM_DEPTH - 1);

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  opcode;
    logic [7:0]  imm_first;
    logic [7:0]  imm_second;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] next_pc;
    logic [7:0]  acc_value;
    logic [3:0]  flag_bits;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic        mem_written;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        unimplemented;

    cpu8_load_alu_execute_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .imm_first(imm_first),
        .imm_second(imm_second),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .next_pc(next_pc),
        .acc_value(acc_value),
        .flag_bits(flag_bits),
        .pair_bc(pair_bc),
        .pair_de(pair_de),
        .pair_hl(pair_hl),
        .mem_written(mem_written),
        .write_addr(write_addr),
        .write_data(write_data),
        .unimplemented(unimplemented)
    );

    // Shadow machine state kept by the predictor. The register file is indexed by
    // operand code, so slot 6 (the (HL) code) is never used.
    logic [7:0]  shadow_regs [8];
    logic [3:0]  shadow_flags;
    logic [15:0] shadow_pc;
    logic [7:0]  shadow_mem [int];
    logic [15:0] stored_addrs [$];

    state_word_t pending_results [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_request;
    int          hold_left;
    int          idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] shadow_pair(input logic [2:0] hi);
        return {shadow_regs[hi], shadow_regs[hi + 3'd1]};
    endfunction

    function automatic logic [15:0] shadow_hl();
        return {shadow_regs[REG_H], shadow_regs[REG_L]};
    endfunction

    // Tells whether the instruction reads data memory and at which address.
    function automatic logic reads_memory(input logic [7:0] op, input logic [7:0] i1,
                                          input logic [7:0] i2, output logic [15:0] addr);
        addr = shadow_hl();
        if (op >= 8'h40 && op < 8'hC0 && op != OP_HALT && op[2:0] == REG_HL)
            return 1'b1;
        case (op)
            OP_LD_A_BC:  addr = shadow_pair(REG_B);
            OP_LD_A_DE:  addr = shadow_pair(REG_D);
            OP_LD_A_HLI, OP_LD_A_HLD: addr = shadow_hl();
            OP_LDH_A_A8: addr = {HIGH_PAGE, i1};
            OP_LD_A_C:   addr = {HIGH_PAGE, shadow_regs[REG_C]};
            OP_LD_A_A16: addr = {i2, i1};
            default:     return 1'b0;
        endcase
        addr = addr & ADDR_MASK;
        return 1'b1;
    endfunction

    // Executes one instruction on the shadow state and returns the word the block
    // should report for it.
    function automatic state_word_t execute_instruction(input logic [7:0] op,
                                                        input logic [7:0] i1,
                                                        input logic [7:0] i2);
        state_word_t res;
        logic [15:0] hl;
        logic [15:0] addr;
        logic [7:0]  val;
        logic [7:0]  acc;
        logic [8:0]  sum;
        logic [3:0]  fl;
        logic        cin;
        logic        store;
        logic [7:0]  store_val;
        logic [1:0]  len;
        alu_op_t     kind;

        hl = shadow_hl();
        acc = shadow_regs[REG_A];
        res = '0;
        len = 2'd1;
        store = 1'b0;
        store_val = acc;
        addr = hl;
        if (op == OP_NOP)
        begin
        end
        else if (op >= 8'h40 && op < 8'h80 && op != OP_HALT)
        begin
            val = (op[2:0] == REG_HL) ? shadow_mem[hl & ADDR_MASK] : shadow_regs[op[2:0]];
            if (op[5:3] == REG_HL)
            begin
                store = 1'b1;
                store_val = val;
            end
            else
                shadow_regs[op[5:3]] = val;
        end
        else if (op < 8'h40 && op[2:0] == 3'd6)
        begin
            len = 2'd2;
            if (op[5:3] == REG_HL)
            begin
                store = 1'b1;
                store_val = i1;
            end
            else
                shadow_regs[op[5:3]] = i1;
        end
        else if (op >= 8'h80 && op < 8'hC0)
        begin
            val = (op[2:0] == REG_HL) ? shadow_mem[hl & ADDR_MASK] : shadow_regs[op[2:0]];
            kind = alu_op_t'(op[5:3]);
            cin = shadow_flags[0];
            fl = 4'b0000;
            case (kind)
                ALU_ADD, ALU_ADC:
                begin
                    if (kind == ALU_ADD)
                        cin = 1'b0;
                    sum = {1'b0, acc} + {1'b0, val} + 9'(cin);
                    fl[1] = ({1'b0, acc[3:0]} + {1'b0, val[3:0]} + 5'(cin)) > 5'h0F;
                    fl[0] = sum[8];
                end
                ALU_SUB, ALU_SBC, ALU_CP:
                begin
                    if (kind != ALU_SBC)
                        cin = 1'b0;
                    sum = {1'b0, acc} - {1'b0, val} - 9'(cin);
                    fl[2] = 1'b1;
                    fl[1] = {1'b0, acc[3:0]} < ({1'b0, val[3:0]} + 5'(cin));
                    fl[0] = {1'b0, acc} < ({1'b0, val} + 9'(cin));
                end
                ALU_AND:
                begin
                    sum = {1'b0, acc & val};
                    fl[1] = 1'b1;
                end
                ALU_XOR: sum = {1'b0, acc ^ val};
                default: sum = {1'b0, acc | val};
            endcase
            fl[3] = (sum[7:0] == 8'h00);
            shadow_flags = fl;
            if (kind != ALU_CP)
                shadow_regs[REG_A] = sum[7:0];
        end
        else
        begin
            case (op)
                OP_LD_BC_A:  begin store = 1'b1; addr = shadow_pair(REG_B); end
                OP_LD_DE_A:  begin store = 1'b1; addr = shadow_pair(REG_D); end
                OP_LD_HLI_A:
                begin
                    store = 1'b1;
                    {shadow_regs[REG_H], shadow_regs[REG_L]} = hl + 16'd1;
                end
                OP_LD_HLD_A:
                begin
                    store = 1'b1;
                    {shadow_regs[REG_H], shadow_regs[REG_L]} = hl - 16'd1;
                end
                OP_LD_A_BC:  shadow_regs[REG_A] = shadow_mem[shadow_pair(REG_B) & ADDR_MASK];
                OP_LD_A_DE:  shadow_regs[REG_A] = shadow_mem[shadow_pair(REG_D) & ADDR_MASK];
                OP_LD_A_HLI:
                begin
                    shadow_regs[REG_A] = shadow_mem[hl & ADDR_MASK];
                    {shadow_regs[REG_H], shadow_regs[REG_L]} = hl + 16'd1;
                end
                OP_LD_A_HLD:
                begin
                    shadow_regs[REG_A] = shadow_mem[hl & ADDR_MASK];
                    {shadow_regs[REG_H], shadow_regs[REG_L]} = hl - 16'd1;
                end
                OP_LDH_A8_A: begin len = 2'd2; store = 1'b1; addr = {HIGH_PAGE, i1}; end
                OP_LDH_A_A8:
                begin
                    len = 2'd2;
                    shadow_regs[REG_A] = shadow_mem[{HIGH_PAGE, i1} & ADDR_MASK];
                end
                OP_LD_C_A:   begin store = 1'b1; addr = {HIGH_PAGE, shadow_regs[REG_C]}; end
                OP_LD_A_C:
                begin
                    shadow_regs[REG_A] =
                        shadow_mem[{HIGH_PAGE, shadow_regs[REG_C]} & ADDR_MASK];
                end
                OP_LD_A16_A: begin len = 2'd3; store = 1'b1; addr = {i2, i1}; end
                OP_LD_A_A16:
                begin
                    len = 2'd3;
                    shadow_regs[REG_A] = shadow_mem[{i2, i1} & ADDR_MASK];
                end
                default:     res.u = 1'b1;
            endcase
        end
        if (store)
        begin
            addr = addr & ADDR_MASK;
            if (!shadow_mem.exists(int'(addr)))
                stored_addrs.push_back(addr);
            shadow_mem[int'(addr)] = store_val;
            res.w = 1'b1;
            res.wa = addr;
            res.wd = store_val;
        end
        shadow_pc = shadow_pc + 16'(len);
        res.pc = shadow_pc;
        res.a = shadow_regs[REG_A];
        res.f = shadow_flags;
        res.bc = shadow_pair(REG_B);
        res.de = shadow_pair(REG_D);
        res.hl = shadow_hl();
        return res;
    endfunction

    // Builds a random instruction word. A read of a byte never stored is turned
    // into the matching store to the same address, which fills memory so that
    // later reads at that address succeed.
    task automatic make_random_word(output logic [7:0] op, output logic [7:0] i1,
                                    output logic [7:0] i2);
        logic [15:0] addr;
        logic [15:0] pick;
        op = 8'($urandom_range(0, 255));
        i1 = 8'($urandom_range(0, 255));
        i2 = 8'($urandom_range(0, 255));
        if (op == OP_LD_A_A16 && stored_addrs.size() > 0 && $urandom_range(0, 1) == 0)
        begin
            pick = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
            {i2, i1} = pick;
        end
        if (reads_memory(op, i1, i2, addr) && !shadow_mem.exists(int'(addr)))
        begin
            case (op)
                OP_LD_A_BC:  op = OP_LD_BC_A;
                OP_LD_A_DE:  op = OP_LD_DE_A;
                OP_LDH_A_A8: op = OP_LDH_A8_A;
                OP_LD_A_C:   op = OP_LD_C_A;
                OP_LD_A_A16: op = OP_LD_A16_A;
                default:     op = 8'h36;   // ld (hl),d8 stores at HL
            endcase
        end
    endtask

    // Offers one word to the block, with random idle cycles before it, and
    // returns after the word has been accepted.
    task automatic send_word(input logic [7:0] op, input logic [7:0] i1,
                             input logic [7:0] i2);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        imm_first <= i1;
        imm_second <= i2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        error_count++;
    endtask

    // Receiver: random stalls, plus a long hold-off on request so the block fills.
    always @(posedge clk)
    begin
        if (hold_request != 0 && hold_left == 0)
        begin
            hold_left <= 400;
            hold_request <= 0;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker: each word taken by the receiver is held against the oldest
    // expected word, field by field.
    always @(posedge clk)
    begin
        state_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("result word with no instruction pending, pc %h", next_pc);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (next_pc !== want.pc) report_mismatch("next_pc", next_pc, want.pc);
                if (acc_value !== want.a)
                    report_mismatch("acc_value", 16'(acc_value), 16'(want.a));
                if (flag_bits !== want.f)
                    report_mismatch("flag_bits", 16'(flag_bits), 16'(want.f));
                if (pair_bc !== want.bc) report_mismatch("pair_bc", pair_bc, want.bc);
                if (pair_de !== want.de) report_mismatch("pair_de", pair_de, want.de);
                if (pair_hl !== want.hl) report_mismatch("pair_hl", pair_hl, want.hl);
                if (mem_written !== want.w)
                    report_mismatch("mem_written", 16'(mem_written), 16'(want.w));
                if (write_addr !== want.wa)
                    report_mismatch("write_addr", write_addr, want.wa);
                if (write_data !== want.wd)
                    report_mismatch("write_data", 16'(write_data), 16'(want.wd));
                if (unimplemented !== want.u)
                    report_mismatch("unimplemented", 16'(unimplemented), 16'(want.u));
            end
        end
    end

    // Watchdog: a long run of cycles with no word moving on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        dir_row_t    dir_table [NUM_DIR];
        state_word_t want;
        logic [7:0]  op;
        logic [7:0]  i1;
        logic [7:0]  i2;

        // The first rows start from reset, so their results are written out here.
        // The rest are ordered so every memory read hits a byte stored earlier.
        dir_table = '{
            '{OP_NOP, 8'h00, 8'h00, 1'b1,
              '{16'h0001, 8'h00, 4'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0, 8'h00, 1'b0}},
            '{8'h3E, 8'hFF, 8'h00, 1'b1,
              '{16'h0003, 8'hFF, 4'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0, 8'h00, 1'b0}},
            '{8'h87, 8'h00, 8'h00, 1'b1,      // add a,a: half carry and carry
              '{16'h0004, 8'hFE, 4'h3, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0, 8'h00, 1'b0}},
            '{OP_HALT, 8'hFF, 8'hFF, 1'b1,    // halt is outside the subset
              '{16'h0005, 8'hFE, 4'h3, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0, 8'h00, 1'b1}},
            '{8'hD3, 8'h00, 8'h00, 1'b0, '0},
            '{8'h8F, 8'h00, 8'h00, 1'b0, '0},  // adc a,a with carry in
            '{OP_LD_A16_A, 8'h00, 8'h00, 1'b0, '0},
            '{OP_LD_A16_A, 8'hFF, 8'hFF, 1'b0, '0},
            '{OP_LD_A_A16, 8'hFF, 8'hFF, 1'b0, '0},
            '{OP_LDH_A8_A, 8'hFF, 8'h00, 1'b0, '0},
            '{OP_LDH_A_A8, 8'hFF, 8'h00, 1'b0, '0},
            '{8'h0E, 8'h80, 8'h00, 1'b0, '0},
            '{OP_LD_C_A, 8'h00, 8'h00, 1'b0, '0},
            '{OP_LD_A_C, 8'h00, 8'h00, 1'b0, '0},
            '{OP_LD_HLD_A, 8'h00, 8'h00, 1'b0, '0},  // HL wraps down to FFFF
            '{OP_LD_HLI_A, 8'h00, 8'h00, 1'b0, '0},  // HL wraps up to 0000
            '{OP_LD_A_HLD, 8'h00, 8'h00, 1'b0, '0},
            '{OP_LD_A_HLI, 8'h00, 8'h00, 1'b0, '0},
            '{8'h36, 8'h5A, 8'h00, 1'b0, '0},
            '{8'h96, 8'h00, 8'h00, 1'b0, '0},
            '{8'h9E, 8'h00, 8'h00, 1'b0, '0},
            '{8'hA6, 8'h00, 8'h00, 1'b0, '0},
            '{8'hAE, 8'h00, 8'h00, 1'b0, '0},
            '{8'hB6, 8'h00, 8'h00, 1'b0, '0},
            '{8'hBE, 8'h00, 8'h00, 1'b0, '0},
            '{8'hBF, 8'h00, 8'h00, 1'b0, '0},  // cp a,a sets zero
            '{8'h86, 8'h00, 8'h00, 1'b0, '0},
            '{8'h8E, 8'h00, 8'h00, 1'b0, '0},
            '{OP_LD_BC_A, 8'h00, 8'h00, 1'b0, '0},
            '{OP_LD_A_BC, 8'h00, 8'h00, 1'b0, '0},
            '{OP_LD_DE_A, 8'h00, 8'h00, 1'b0, '0},
            '{OP_LD_A_DE, 8'h00, 8'h00, 1'b0, '0},
            '{8'h70, 8'h00, 8'h00, 1'b0, '0}
        };

        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = '0;
        imm_first = '0;
        imm_second = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        idle_cycles = 0;
        for (int k = 0; k < 8; k++)
            shadow_regs[k] = 8'h00;
        shadow_flags = 4'h0;
        shadow_pc = 16'h0000;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed table runs with no idling on either side.
        for (int n = 0; n < NUM_DIR; n++)
        begin
            want = execute_instruction(dir_table[n].op, dir_table[n].i1, dir_table[n].i2);
            if (dir_table[n].typed)
                want = dir_table[n].r;
            pending_results.push_back(want);
            send_word(dir_table[n].op, dir_table[n].i1, dir_table[n].i2);
        end

        // Random words in four idling phases. The long receiver hold-off comes at
        // the start of the first one, while words keep arriving back to back.
        for (int n = 0; n < NUM_RAND; n++)
        begin
            case (n)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_request = 1;
                end
                NUM_RAND / 4:     begin send_idle_pct = 80; recv_stall_pct = 0;  end
                NUM_RAND / 2:     begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3 * NUM_RAND / 4: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default:
                begin
                end
            endcase
            make_random_word(op, i1, i2);
            pending_results.push_back(execute_instruction(op, i1, i2));
            send_word(op, i1, i2);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
